### design/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// No dependencies; imported by the core and its checker.
package qrs_pkg;

	localparam int COEF_WIDTH = 16;
	localparam int ROOT_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	typedef enum logic [1:0] {
		ST_TWO     = 2'd0,
		ST_DOUBLE  = 2'd1,
		ST_COMPLEX = 2'd2,
		ST_AZERO   = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] coef_a;
		logic signed [COEF_WIDTH-1:0] coef_b;
		logic signed [COEF_WIDTH-1:0] coef_c;
	} coef_t;

	typedef struct packed {
		status_t                      root_status;
		logic signed [ROOT_WIDTH-1:0] root_plus;
		logic signed [ROOT_WIDTH-1:0] root_minus;
	} root_t;

endpackage

### design/qrs_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Standalone; instantiated by quadratic_root_solver_core.
module qrs_isqrt #(
	parameter int RW = 17
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] radicand,
	output logic [RW-1:0]   root
);

	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] rad_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+1:0]   rem_i;
		logic [RW+1:0]   remx;
		logic [RW+1:0]   trial;
		logic [RW-1:0]   root_i;
		logic [2*RW-1:0] rad_i;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = radicand;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i  = rad_s[k-1];
		end

		// remainder stays below 2^RW before the shift
		assign remx  = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
		assign trial = {root_i, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (remx >= trial) begin
					rem_s[k]  <= remx - trial;
					root_s[k] <= {root_i[RW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= remx;
					root_s[k] <= {root_i[RW-2:0], 1'b0};
				end
				rad_s[k] <= rad_i << 2;
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

### design/qrs_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone; instantiated twice by quadratic_root_solver_core.
module qrs_div #(
	parameter int NW = 33,
	parameter int VW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [NW-1:0] quotient
);

	logic [VW-1:0] rem_s [NW];
	logic [NW-1:0] quo_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [VW-1:0] dv_s  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [VW-1:0] rem_i;
		logic [NW-1:0] quo_i;
		logic [NW-1:0] num_i;
		logic [VW-1:0] dv_i;
		logic [VW:0]   remx;
		logic [VW:0]   diff;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign quo_i = '0;
			assign num_i = dividend;
			assign dv_i  = divisor;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign quo_i = quo_s[k-1];
			assign num_i = num_s[k-1];
			assign dv_i  = dv_s[k-1];
		end

		assign remx = {rem_i, num_i[NW-1]};
		assign diff = remx - {1'b0, dv_i};

		always_ff @(posedge clk) begin
			if (en) begin
				if (remx >= {1'b0, dv_i}) begin
					rem_s[k] <= diff[VW-1:0];
					quo_s[k] <= {quo_i[NW-2:0], 1'b1};
				end else begin
					rem_s[k] <= remx[VW-1:0];
					quo_s[k] <= {quo_i[NW-2:0], 1'b0};
				end
				num_s[k] <= num_i << 1;
				dv_s[k]  <= dv_i;
			end
		end
	end

	assign quotient = quo_s[NW-1];

endmodule

### design/quadratic_root_solver_core.sv
// Top level of the quadratic root solver: multiply, discriminant, square root,
// divide and saturate stages. Depends on qrs_pkg, qrs_isqrt and qrs_div.

// Accepts one equation (a, b, c in signed Q8.8) per clock while coef_ready is
// high and returns one result beat per equation, in order. The square root
// resolves one root bit per stage and the two dividers resolve one quotient
// bit per stage. The whole pipe advances whenever the output register is
// empty or being taken, so coef_ready follows root_ready within the same
// cycle.
// Status 0 gives two roots, 1 a double root in both fields, 2 complex
// roots and 3 a zero leading coefficient; the last two return zero roots.
// Roots are Q16.16, truncated toward zero and saturated.
module quadratic_root_solver_core
	import qrs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  coef_t coef,
	input  logic  coef_valid,
	output logic  coef_ready,
	output root_t root,
	output logic  root_valid,
	input  logic  root_ready
);

	localparam int CW  = COEF_WIDTH;
	localparam int RW  = ROOT_WIDTH;
	localparam int B2W = 2*CW - 1;
	localparam int DW  = 2*CW + 1;
	localparam int SQ  = CW + 1;
	localparam int NW  = CW + 1 + FRAC_BITS;
	localparam int VW  = CW + 1;
	localparam int XW  = (RW > NW + 1) ? RW : NW + 1;

	logic en;

	// ---- stage 1: products
	logic                   v_s1;
	logic signed [CW-1:0]   a_s1, b_s1;
	logic [B2W-1:0]         b2_s1;
	logic signed [2*CW-1:0] ac_s1;
	logic signed [2*CW-1:0] bb;

	assign bb = coef.coef_b * coef.coef_b;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef.coef_a;
			b_s1  <= coef.coef_b;
			b2_s1 <= bb[B2W-1:0];
			ac_s1 <= coef.coef_a * coef.coef_c;
		end
	end

	// ---- stage 2: discriminant and class
	logic                 v_s2;
	logic signed [CW-1:0] a_s2, b_s2;
	logic [DW-1:0]        d_s2;
	status_t              st_s2;
	logic [2*CW-1:0]      acm;
	logic [2*CW+1:0]      f4;
	logic [DW-1:0]        fd, b2d, dsum, ddif;
	logic                 cplx;
	logic [DW-1:0]        d_nx;
	status_t              st_nx;

	always_comb begin
		acm   = ac_s1[2*CW-1] ? (2*CW)'(-ac_s1) : (2*CW)'(ac_s1);
		f4    = {acm, 2'b00};
		fd    = f4[DW-1:0];
		b2d   = DW'(b2_s1);
		dsum  = b2d + fd;
		ddif  = b2d - fd;
		cplx  = !ac_s1[2*CW-1] && (fd > b2d);
		d_nx  = '0;
		st_nx = ST_TWO;
		if (a_s1 == '0) begin
			st_nx = ST_AZERO;
		end else if (ac_s1[2*CW-1] || ac_s1 == '0) begin
			d_nx = dsum;
		end else if (cplx) begin
			st_nx = ST_COMPLEX;
		end else begin
			d_nx = ddif;
		end
		if (st_nx == ST_TWO && d_nx == '0)
			st_nx = ST_DOUBLE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			d_s2  <= d_nx;
			st_s2 <= st_nx;
		end
	end

	// ---- stage group 3: square root, side data rides alongside
	logic [SQ-1:0]        s_root;
	logic                 v_s3  [SQ];
	logic signed [CW-1:0] a_s3  [SQ];
	logic signed [CW-1:0] b_s3  [SQ];
	status_t              st_s3 [SQ];

	qrs_isqrt #(.RW(SQ)) u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({1'b0, d_s2}),
		.root     (s_root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3[0]  <= a_s2;
			b_s3[0]  <= b_s2;
			st_s3[0] <= st_s2;
			for (int k = 1; k < SQ; k++) begin
				a_s3[k]  <= a_s3[k-1];
				b_s3[k]  <= b_s3[k-1];
				st_s3[k] <= st_s3[k-1];
			end
		end
	end

	// ---- stage 4: numerators, divisor, quotient signs
	logic                 v_s4;
	logic [NW-1:0]        np_s4, nm_s4;
	logic [VW-1:0]        dv_s4;
	logic                 negp_s4, negm_s4;
	status_t              st_s4;
	logic signed [CW+1:0] bx, sx, n_p, n_m;
	logic [CW+1:0]        mp, mm;
	logic [CW-1:0]        am;
	logic signed [CW-1:0] a_l;

	always_comb begin
		a_l = a_s3[SQ-1];
		bx  = (CW+2)'(b_s3[SQ-1]);
		sx  = $signed({1'b0, s_root});
		n_p = sx - bx;
		n_m = -bx - sx;
		mp  = n_p[CW+1] ? (CW+2)'(-n_p) : n_p;
		mm  = n_m[CW+1] ? (CW+2)'(-n_m) : n_m;
		am  = a_l[CW-1] ? CW'(-a_l) : a_l;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s4   <= {mp[CW:0], {FRAC_BITS{1'b0}}};
			nm_s4   <= {mm[CW:0], {FRAC_BITS{1'b0}}};
			dv_s4   <= {am, 1'b0};
			negp_s4 <= n_p[CW+1] ^ a_l[CW-1];
			negm_s4 <= n_m[CW+1] ^ a_l[CW-1];
			st_s4   <= st_s3[SQ-1];
		end
	end

	// ---- stage group 5: two dividers
	logic [NW-1:0] qp, qm;
	logic          v_s5    [NW];
	logic          negp_s5 [NW];
	logic          negm_s5 [NW];
	status_t       st_s5   [NW];

	qrs_div #(.NW(NW), .VW(VW)) u_div_plus (
		.clk      (clk),
		.en       (en),
		.dividend (np_s4),
		.divisor  (dv_s4),
		.quotient (qp)
	);

	qrs_div #(.NW(NW), .VW(VW)) u_div_minus (
		.clk      (clk),
		.en       (en),
		.dividend (nm_s4),
		.divisor  (dv_s4),
		.quotient (qm)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			negp_s5[0] <= negp_s4;
			negm_s5[0] <= negm_s4;
			st_s5[0]   <= st_s4;
			for (int k = 1; k < NW; k++) begin
				negp_s5[k] <= negp_s5[k-1];
				negm_s5[k] <= negm_s5[k-1];
				st_s5[k]   <= st_s5[k-1];
			end
		end
	end

	// ---- stage 6: sign, saturate, output register
	logic                 v_s6;
	root_t                out_s6;
	logic signed [NW:0]   sp, sm;
	logic signed [XW-1:0] xp, xm;
	logic [RW-1:0]        rp, rm;
	status_t              st_l;
	logic                 has_root;

	function automatic logic [RW-1:0] sat_root(input logic signed [XW-1:0] x);
		logic [XW-RW:0] upper;
		upper = x[XW-1:RW-1];
		if (&upper || ~|upper)
			return x[RW-1:0];
		return x[XW-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
	endfunction

	always_comb begin
		st_l     = st_s5[NW-1];
		sp       = negp_s5[NW-1] ? -$signed({1'b0, qp}) : $signed({1'b0, qp});
		sm       = negm_s5[NW-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
		xp       = XW'(sp);
		xm       = XW'(sm);
		has_root = (st_l == ST_TWO) || (st_l == ST_DOUBLE);
		rp       = has_root ? sat_root(xp) : '0;
		rm       = has_root ? sat_root(xm) : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s6.root_status <= st_l;
			out_s6.root_plus   <= rp;
			out_s6.root_minus  <= rm;
		end
	end

	// ---- valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s4 <= 1'b0;
			v_s6 <= 1'b0;
			for (int k = 0; k < SQ; k++)
				v_s3[k] <= 1'b0;
			for (int k = 0; k < NW; k++)
				v_s5[k] <= 1'b0;
		end else if (en) begin
			v_s1    <= coef_valid;
			v_s2    <= v_s1;
			v_s3[0] <= v_s2;
			for (int k = 1; k < SQ; k++)
				v_s3[k] <= v_s3[k-1];
			v_s4    <= v_s3[SQ-1];
			v_s5[0] <= v_s4;
			for (int k = 1; k < NW; k++)
				v_s5[k] <= v_s5[k-1];
			v_s6    <= v_s5[NW-1];
		end
	end

	assign en         = !v_s6 || root_ready;
	assign coef_ready = en;
	assign root_valid = v_s6;
	assign root       = out_s6;

endmodule

### design/qrs_checker.sv
// Port-level checker for quadratic_root_solver_core, bound to the top level.
// Depends on qrs_pkg.
module qrs_checker
	import qrs_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input coef_t coef,
	input logic  coef_valid,
	input logic  coef_ready,
	input root_t root,
	input logic  root_valid,
	input logic  root_ready
);

	// a held result beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && !root_ready |=> root_valid && $stable(root))
		else $error("result beat changed while stalled");

	// pipe moves whenever the output slot frees up
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		coef_ready == (!root_valid || root_ready))
		else $error("input ready does not track output slot");

	a_noroot: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && (root.root_status == ST_COMPLEX || root.root_status == ST_AZERO)
		|-> root.root_plus == '0 && root.root_minus == '0)
		else $error("roots not zero for complex or zero-a case");

	a_double: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root.root_status == ST_DOUBLE |-> root.root_plus == root.root_minus)
		else $error("double root fields differ");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (.*);

### test/tb_quadratic_root_solver_core.sv
// Testbench for quadratic_root_solver_core: directed table plus random equations,
// checked against an in-bench root predictor. Depends on qrs_pkg and the core RTL.
module tb_quadratic_root_solver_core;
	import qrs_pkg::*;

	localparam int LATENCY = 54;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	coef_t coef = '0;
	logic  coef_valid = 1'b0;
	logic  coef_ready;
	root_t root;
	logic  root_valid;
	logic  root_ready = 1'b0;

	root_t pending_roots[$];
	int    mismatch_count = 0;
	int    roots_checked = 0;
	int    eqs_sent = 0;
	int    send_idle_pct = 18;
	int    recv_idle_pct = 68;
	int    hold_off_cycles = 0;

	quadratic_root_solver_core uut (
		.clk(clk), .arst_n(arst_n),
		.coef(coef), .coef_valid(coef_valid), .coef_ready(coef_ready),
		.root(root), .root_valid(root_valid), .root_ready(root_ready)
	);

	always #5 clk = ~clk;

	// Q16.16 quotient, truncated toward zero, saturated to ROOT_WIDTH
	function automatic logic signed [ROOT_WIDTH-1:0] q16_quot(longint num, longint den);
		longint q;
		q = (num * 65536) / den;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[ROOT_WIDTH-1:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [65:0] d);
		logic [65:0] rem;
		logic [65:0] trial;
		logic [63:0] r;
		rem = '0;
		r = '0;
		for (int p = 32; p >= 0; p--) begin
			rem = (rem << 2) | ((d >> (2 * p)) & 66'd3);
			trial = ({2'b0, r} << 2) | 66'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				r = (r << 1) | 64'd1;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

	function automatic root_t solve_roots(coef_t eq);
		root_t res;
		longint a, b, c, s;
		logic signed [67:0] disc;
		a = eq.coef_a;
		b = eq.coef_b;
		c = eq.coef_c;
		res = '0;
		if (a == 0) begin
			res.root_status = ST_AZERO;
			return res;
		end
		disc = 68'(b) * 68'(b) - 68'sd4 * 68'(a) * 68'(c);
		if (disc < 0) begin
			res.root_status = ST_COMPLEX;
		end else if (disc == 0) begin
			res.root_status = ST_DOUBLE;
			res.root_plus = q16_quot(-b, 2 * a);
			res.root_minus = res.root_plus;
		end else begin
			s = longint'(floor_sqrt(disc[65:0]));
			res.root_status = ST_TWO;
			res.root_plus = q16_quot(-b + s, 2 * a);
			res.root_minus = q16_quot(-b - s, 2 * a);
		end
		return res;
	endfunction

	// valid drops only while the sender idles, so beats can run back to back
	task automatic send_eq(coef_t eq, bit has_known, root_t known);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			coef_valid <= 1'b0;
			@(negedge clk);
		end
		pending_roots.push_back(has_known ? known : solve_roots(eq));
		coef <= eq;
		coef_valid <= 1'b1;
		do @(posedge clk); while (!coef_ready);
		eqs_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		coef_valid <= 1'b0;
		while (pending_roots.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_coef();
		case ($urandom_range(5, 0))
			0: return 16'($urandom_range(3, 0)) - 16'sd1;
			1: return 16'sh8000 + 16'($urandom_range(3, 0));
			2: return 16'sh7fff - 16'($urandom_range(3, 0));
			3: return 16'($urandom_range(2047, 0)) - 16'sd1024;
			default: return 16'($urandom);
		endcase
	endfunction

	// Receiver: random stalls, or a counted long hold-off
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			root_ready <= 1'b0;
		end else begin
			root_ready <= arst_n && ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (root_valid && root_ready) begin
			if (pending_roots.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected root beat: %p", root);
			end else begin
				root_t exp_root;
				exp_root = pending_roots.pop_front();
				roots_checked++;
				if (root.root_status !== exp_root.root_status ||
				    root.root_plus !== exp_root.root_plus ||
				    root.root_minus !== exp_root.root_minus) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp st=%0d +%0d -%0d got st=%0d +%0d -%0d",
							exp_root.root_status, exp_root.root_plus, exp_root.root_minus,
							root.root_status, root.root_plus, root.root_minus);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb_quadratic_root_solver_core: errors");
		$finish;
	end

	typedef struct {
		logic signed [15:0] a, b, c;
		bit    has_known;
		root_t known;
	} eq_row_t;

	initial begin
		eq_row_t rows[$];
		coef_t eq;
		logic signed [15:0] k;
		rows = '{
			'{16'sd0, 16'sd5, 16'sd7, 1, '{ST_AZERO, 32'sd0, 32'sd0}},
			'{16'sd0, 16'sh7fff, 16'sh8000, 1, '{ST_AZERO, 32'sd0, 32'sd0}},
			'{16'sd256, 16'sd0, 16'sd256, 1, '{ST_COMPLEX, 32'sd0, 32'sd0}},
			'{16'sh7fff, 16'sd0, 16'sh7fff, 1, '{ST_COMPLEX, 32'sd0, 32'sd0}},
			// x^2 - 2x + 1: double root at 1.0
			'{16'sd256, -16'sd512, 16'sd256, 1, '{ST_DOUBLE, 32'sh10000, 32'sh10000}},
			// x^2 - 1: roots +1 and -1
			'{16'sd256, 16'sd0, -16'sd256, 1, '{ST_TWO, 32'sh10000, -32'sh10000}},
			'{16'sd1, 16'sh7fff, 16'sd0, 0, '0},
			'{16'sd1, 16'sh8000, 16'sd0, 0, '0},
			'{-16'sd1, 16'sh8000, 16'sh7fff, 0, '0},
			'{16'sh8000, 16'sh8000, 16'sh8000, 0, '0},
			'{16'sh8000, 16'sh7fff, 16'sh7fff, 0, '0},
			'{16'sh7fff, 16'sh7fff, 16'sh8000, 0, '0},
			'{16'sh7fff, 16'sh8000, 16'sh7fff, 0, '0},
			'{-16'sd1, 16'sd0, 16'sd0, 0, '0},
			'{16'sd1, 16'sd2, 16'sd1, 0, '0},
			'{16'sd3, 16'sd5, -16'sd7, 0, '0},
			'{16'shffff, 16'shffff, 16'shffff, 0, '0},
			'{16'sh5555, 16'shaaaa, 16'sh5555, 0, '0}
		};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			eq = '{rows[i].a, rows[i].b, rows[i].c};
			send_eq(eq, rows[i].has_known, rows[i].known);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 68 : 0;
			recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 18 : 0;
			if (phase == 2) hold_off_cycles <= 200;
			for (int n = 0; n < 280; n++) begin
				eq.coef_a = rand_coef();
				eq.coef_b = rand_coef();
				// about a quarter are built as a*(x+k)^2 to hit a zero discriminant
				if ($urandom_range(3, 0) == 0 && eq.coef_a != 0) begin
					k = 16'($urandom_range(15, 0));
					eq.coef_b = 16'sd2 * k * eq.coef_a;
					eq.coef_c = k * k * eq.coef_a;
				end else begin
					eq.coef_c = rand_coef();
				end
				send_eq(eq, 0, '0);
			end
			// sender waits out every outstanding root before the next phase
			drain();
		end

		$display("sent %0d equations, checked %0d root beats across three stall mixes",
			eqs_sent, roots_checked);
		if (mismatch_count == 0 && pending_roots.size() == 0)
			$display("tb_quadratic_root_solver_core: clean");
		else
			$display("tb_quadratic_root_solver_core: errors");
		$finish;
	end
endmodule
